>>> rtl/core/e1c_pkg.sv
// e1c_pkg: shared constants for the 1d euler conserved-to-primitive block
// no dependencies

package e1c_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_M1    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_RATIO = 1'b1;

  localparam logic [16:0] GAMMA_M1_RESET    = 17'd26214;
  localparam logic [30:0] GAMMA_RATIO_RESET = 31'd229376;

endpackage

>>> rtl/core/euler1d_cons_to_prim.sv
// euler1d_cons_to_prim: conserved-to-primitive conversion, one grid cell per word
// depends on e1c_pkg

// One cell word enters per clock while the pipe is not held (Q16.16 at the default
// FRAC_BITS): velocity and specific energy come from two bit-per-stage restoring
// dividers of 32 + FRAC_BITS stages that run side by side on one divisor, followed
// by eight stages for u^2/2, RT, pressure and enthalpy with saturation. The whole
// pipe holds while the result word is stalled.
module euler1d_cons_to_prim #(
  parameter int FRAC_BITS = e1c_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [e1c_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [30:0]                    density,
  input  logic signed [31:0]             momentum,
  input  logic signed [31:0]             energy_density,
  input  logic                           end_of_line,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [30:0]                    density_out,
  output logic signed [31:0]             velocity,
  output logic signed [31:0]             pressure,
  output logic signed [31:0]             enthalpy,
  output logic signed [31:0]             gas_rt,
  output logic                           saturated,
  output logic                           end_of_line_out
);
  import e1c_pkg::*;

  localparam int NW  = 32 + FRAC_BITS;
  localparam int HW  = 63 - FRAC_BITS;
  localparam int EW  = ((NW > HW) ? NW : HW) + 2;
  localparam int EH  = EW - 32;
  localparam int CW  = EW + 18;
  localparam int HSW = ((HW > 33) ? HW : 33) + 2;

  function automatic logic [CW-1:0] lim_of(input logic neg);
    logic [CW-1:0] l;
    begin
      l = CW'(1) << 31;
      if (!neg) l = l - CW'(1);
      return l;
    end
  endfunction

  function automatic logic [31:0] clip_mag(input logic neg, input logic [CW-1:0] mag);
    logic [CW-1:0] l;
    begin
      l = lim_of(neg);
      return (mag > l) ? l[31:0] : mag[31:0];
    end
  endfunction

  function automatic logic over_lim(input logic neg, input logic [CW-1:0] mag);
    return mag > lim_of(neg);
  endfunction

  function automatic logic [32:0] cap33(input logic [CW-1:0] v);
    return (v > (CW'(1) << 32)) ? 33'h1_0000_0000 : v[32:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  logic        adv;
  logic [16:0] gamma_m1;
  logic [30:0] gamma_ratio;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_m1    <= GAMMA_M1_RESET;
      gamma_ratio <= GAMMA_RATIO_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GAMMA_M1:    gamma_m1    <= cfg_data[16:0];
        CFG_GAMMA_RATIO: gamma_ratio <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // divider pipe
  logic [NW-1:0] dv_v;
  logic [30:0]   dv_div [NW];
  logic [30:0]   dv_r   [NW];
  logic          dv_eol [NW];
  logic          dv_nu  [NW];
  logic          dv_ne  [NW];
  logic [30:0]   dv_ru  [NW];
  logic [30:0]   dv_re  [NW];
  logic [NW-1:0] dv_qu  [NW];
  logic [NW-1:0] dv_qe  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_div
    logic          s_v, s_eol, s_nu, s_ne;
    logic [30:0]   s_div, s_r, s_ru, s_re;
    logic [NW-1:0] s_qu, s_qe, nq_u, nq_e;
    logic [31:0]   sh_u, sh_e;
    logic [30:0]   nr_u, nr_e;

    if (k == 0) begin : g_src
      assign s_v   = in_valid;
      assign s_div = (density == 31'd0) ? 31'd1 : density;
      assign s_r   = density;
      assign s_eol = end_of_line;
      assign s_nu  = momentum[31];
      assign s_ne  = energy_density[31];
      assign s_ru  = '0;
      assign s_re  = '0;
      assign s_qu  = NW'(abs32(momentum)) << FRAC_BITS;
      assign s_qe  = NW'(abs32(energy_density)) << FRAC_BITS;
    end else begin : g_src
      assign s_v   = dv_v[k-1];
      assign s_div = dv_div[k-1];
      assign s_r   = dv_r[k-1];
      assign s_eol = dv_eol[k-1];
      assign s_nu  = dv_nu[k-1];
      assign s_ne  = dv_ne[k-1];
      assign s_ru  = dv_ru[k-1];
      assign s_re  = dv_re[k-1];
      assign s_qu  = dv_qu[k-1];
      assign s_qe  = dv_qe[k-1];
    end

    always_comb begin
      sh_u = {s_ru, s_qu[NW-1]};
      nq_u = {s_qu[NW-2:0], 1'b0};
      if (sh_u >= {1'b0, s_div}) begin
        nr_u    = 31'(sh_u - {1'b0, s_div});
        nq_u[0] = 1'b1;
      end else begin
        nr_u = sh_u[30:0];
      end
      sh_e = {s_re, s_qe[NW-1]};
      nq_e = {s_qe[NW-2:0], 1'b0};
      if (sh_e >= {1'b0, s_div}) begin
        nr_e    = 31'(sh_e - {1'b0, s_div});
        nq_e[0] = 1'b1;
      end else begin
        nr_e = sh_e[30:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else if (adv) begin
        dv_v[k] <= s_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_div[k] <= s_div;
        dv_r[k]   <= s_r;
        dv_eol[k] <= s_eol;
        dv_nu[k]  <= s_nu;
        dv_ne[k]  <= s_ne;
        dv_ru[k]  <= nr_u;
        dv_re[k]  <= nr_e;
        dv_qu[k]  <= nq_u;
        dv_qe[k]  <= nq_e;
      end
    end
  end

  // post-divide stages a..h
  logic [7:0] pv;

  logic [30:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r;
  logic        a_eol, b_eol, c_eol, d_eol, e_eol, f_eol, g_eol;
  logic        a_sat, b_sat, c_sat, d_sat, e_sat, f_sat, g_sat;
  logic [31:0] a_upat, b_upat, c_upat, d_upat, e_upat, f_upat, g_upat;
  logic [31:0] a_umag;
  logic signed [NW:0] a_es, b_es;
  logic [HW-1:0] b_half, c_half, d_half, e_half, f_half;
  logic          c_neg, d_neg;
  logic [EW-1:0] c_ea;
  logic [48:0]   d_plo;
  logic [EH+16:0] d_phi;
  logic          e_rneg, f_rneg;
  logic [31:0]   e_rtmag, e_rtpat, f_rtpat, g_rtpat;
  logic [62:0]   f_pp, f_ph;
  logic [31:0]   g_ppat;
  logic signed [HSW-1:0] g_hs;

  logic [NW-1:0] qu_l, qe_l;
  logic          nu_l, ne_l;
  logic signed [EW-1:0] c_eint;
  logic [CW-1:0] e_full, e_sh, e_mag;
  logic [31:0]   e_rtm;
  logic [CW-1:0] g_pmag, h_mag;
  logic [32:0]   g_hm;
  logic signed [HSW-1:0] g_hsum;
  logic          h_neg;
  logic [31:0]   h_m;

  assign qu_l = dv_qu[NW-1];
  assign qe_l = dv_qe[NW-1];
  assign nu_l = dv_nu[NW-1];
  assign ne_l = dv_ne[NW-1];

  always_comb begin
    c_eint = EW'(b_es) - EW'($signed({1'b0, b_half}));
    e_full = CW'({d_phi, 32'b0}) + CW'(d_plo);
    e_sh   = e_full >> FRAC_BITS;
    e_mag  = CW'(cap33(e_sh));
    e_rtm  = clip_mag(d_neg, e_mag);
    g_pmag = CW'(cap33(CW'(f_pp >> FRAC_BITS)));
    g_hm   = cap33(CW'(f_ph >> FRAC_BITS));
    g_hsum = f_rneg ? (HSW'($signed({1'b0, f_half})) - HSW'($signed({1'b0, g_hm})))
                    : (HSW'($signed({1'b0, f_half})) + HSW'($signed({1'b0, g_hm})));
    h_neg  = g_hs[HSW-1];
    h_mag  = h_neg ? CW'(-g_hs) : CW'(g_hs);
    h_m    = clip_mag(h_neg, h_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (adv) begin
      pv <= {pv[6:0], dv_v[NW-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // a: clip velocity, sign specific energy
      a_r    <= dv_r[NW-1];
      a_eol  <= dv_eol[NW-1];
      a_sat  <= over_lim(nu_l, CW'(qu_l));
      a_umag <= clip_mag(nu_l, CW'(qu_l));
      a_upat <= nu_l ? 32'(-clip_mag(nu_l, CW'(qu_l))) : clip_mag(nu_l, CW'(qu_l));
      a_es   <= ne_l ? -$signed({1'b0, qe_l}) : $signed({1'b0, qe_l});
      // b: u^2/2
      b_r    <= a_r;
      b_eol  <= a_eol;
      b_sat  <= a_sat;
      b_upat <= a_upat;
      b_es   <= a_es;
      b_half <= HW'((64'(a_umag) * 64'(a_umag)) >> (FRAC_BITS + 1));
      // c: internal energy
      c_r    <= b_r;
      c_eol  <= b_eol;
      c_sat  <= b_sat;
      c_upat <= b_upat;
      c_half <= b_half;
      c_neg  <= c_eint[EW-1];
      c_ea   <= c_eint[EW-1] ? EW'(-c_eint) : EW'(c_eint);
      // d: partial products by gamma-1
      d_r    <= c_r;
      d_eol  <= c_eol;
      d_sat  <= c_sat;
      d_upat <= c_upat;
      d_half <= c_half;
      d_neg  <= c_neg;
      d_plo  <= 49'(c_ea[31:0]) * 49'(gamma_m1);
      d_phi  <= (EH+17)'(c_ea[EW-1:32]) * (EH+17)'(gamma_m1);
      // e: rt
      e_r     <= d_r;
      e_eol   <= d_eol;
      e_sat   <= d_sat | over_lim(d_neg, e_mag);
      e_upat  <= d_upat;
      e_half  <= d_half;
      e_rneg  <= d_neg && (e_rtm != 32'd0);
      e_rtmag <= e_rtm;
      e_rtpat <= d_neg ? 32'(-e_rtm) : e_rtm;
      // f: pressure and enthalpy products
      f_r     <= e_r;
      f_eol   <= e_eol;
      f_sat   <= e_sat;
      f_upat  <= e_upat;
      f_half  <= e_half;
      f_rneg  <= e_rneg;
      f_rtpat <= e_rtpat;
      f_pp    <= 63'(e_rtmag) * 63'(e_r);
      f_ph    <= 63'(e_rtmag) * 63'(gamma_ratio);
      // g: pressure clip, enthalpy sum
      g_r     <= f_r;
      g_eol   <= f_eol;
      g_sat   <= f_sat | over_lim(f_rneg, g_pmag);
      g_upat  <= f_upat;
      g_rtpat <= f_rtpat;
      g_ppat  <= f_rneg ? 32'(-clip_mag(f_rneg, g_pmag)) : clip_mag(f_rneg, g_pmag);
      g_hs    <= g_hsum;
      // h: enthalpy clip, output word
      density_out     <= g_r;
      end_of_line_out <= g_eol;
      velocity        <= g_upat;
      gas_rt          <= g_rtpat;
      pressure        <= g_ppat;
      enthalpy        <= h_neg ? 32'(-h_m) : h_m;
      saturated       <= g_sat | over_lim(h_neg, h_mag);
    end
  end

  assign out_valid = pv[7];

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dv_v[NW-1] |-> (dv_ru[NW-1] < dv_div[NW-1]) && (dv_re[NW-1] < dv_div[NW-1]))
    else $error("divider remainder not below divisor");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(pv) && $stable(dv_v))
    else $error("pipe moved while held");

  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pv[6]))
    else $error("result word without an item behind it");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({density_out, velocity, pressure,
      enthalpy, gas_rt, saturated, end_of_line_out}))
    else $error("stalled result word changed");

endmodule
